FILE: design/sbsm_pkg.sv
package sbsm_pkg;

  // Program RAM size in bytes; a power of two from 2048 to 32768.
  localparam int unsigned PRG_RAM_BYTES = 8192;
  localparam int unsigned RAM_AW        = $clog2(PRG_RAM_BYTES);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_CPU_READ  = 2'd0,
    OP_CPU_WRITE = 2'd1,
    OP_PPU_READ  = 2'd2,
    OP_PPU_WRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_CONTROL  = 2'd0,
    REG_CHR_LOW  = 2'd1,
    REG_CHR_HIGH = 2'd2,
    REG_PRG      = 2'd3
  } reg_sel_e;

  localparam logic [4:0] CONTROL_RESET = 5'h1C;
  localparam logic [2:0] SHIFT_LAST    = 3'd4;

  typedef struct packed {
    logic        hit;
    logic        ram_access;
    logic [17:0] mapped_address;
    logic        ram_read;
    logic [1:0]  mirroring;
  } res_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage

FILE: design/sbsm_in_if.sv
interface sbsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, output op, output bus_address, output write_data, input ready);
  modport sink (input valid, input op, input bus_address, input write_data, output ready);
endinterface

FILE: design/sbsm_out_if.sv
interface sbsm_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        ram_access;
  logic [17:0] mapped_address;
  logic [7:0]  read_data;
  logic [1:0]  mirroring;

  modport source (output valid, output hit, output ram_access, output mapped_address,
                  output read_data, output mirroring, input ready);
  modport sink (input valid, input hit, input ram_access, input mapped_address,
                input read_data, input mirroring, output ready);
endinterface

FILE: design/sbsm_cfg_if.sv
interface sbsm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sbsm_pkg::CFG_IDX_W-1:0]  index;
  logic [sbsm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/sbsm_ram.sv
module sbsm_ram (
  input  logic               clk_i,
  input  sbsm_pkg::ram_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [sbsm_pkg::PRG_RAM_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sbsm_regs.sv
module sbsm_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic [1:0]                       op_i,
  input  logic [15:0]                      addr_i,
  input  logic [7:0]                       wdata_i,
  input  logic                             cfg_we_i,
  input  logic [sbsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sbsm_pkg::res_t                   res_o,
  output sbsm_pkg::ram_req_t               ram_req_o
);

  logic [4:0] prg_cnt_q, prg_cnt_d;
  logic [4:0] chr_cnt_q, chr_cnt_d;
  logic [4:0] shift_val_q, shift_val_d;
  logic [2:0] shift_cnt_q, shift_cnt_d;
  logic [4:0] ctrl_q, ctrl_d;
  logic [4:0] chr_lo_q, chr_lo_d;
  logic [4:0] chr_hi_q, chr_hi_d;
  logic [4:0] chr_all_q, chr_all_d;
  logic [3:0] prg_lo_q, prg_lo_d;
  logic [3:0] prg_hi_q, prg_hi_d;
  logic [2:0] prg_all_q, prg_all_d;
  logic [1:0] mirror_q, mirror_d;

  logic        is_cpu, in_ram, in_rom, in_chr;
  logic [4:0]  shifted;
  logic [4:0]  last_bank_cfg;
  logic [4:0]  last_bank_cur;
  logic [15:0] ram_off;
  logic [3:0]  prg_bank;
  logic [4:0]  chr_bank;
  sbsm_pkg::op_e      op;
  sbsm_pkg::reg_sel_e sel;

  assign op      = sbsm_pkg::op_e'(op_i);
  assign sel     = sbsm_pkg::reg_sel_e'(addr_i[14:13]);
  assign is_cpu  = (op == sbsm_pkg::OP_CPU_READ) || (op == sbsm_pkg::OP_CPU_WRITE);
  assign in_ram  = addr_i[15:13] == 3'b011;
  assign in_rom  = addr_i[15];
  assign in_chr  = addr_i[15:13] == 3'b000;
  assign shifted = {wdata_i[0], shift_val_q[4:1]};
  assign last_bank_cfg = cfg_data_i - 5'd1;
  assign last_bank_cur = prg_cnt_q - 5'd1;
  assign ram_off  = {3'b000, addr_i[12:0]};
  assign prg_bank = addr_i[14] ? prg_hi_q : prg_lo_q;
  assign chr_bank = addr_i[12] ? chr_hi_q : chr_lo_q;

  always_comb begin
    prg_cnt_d   = prg_cnt_q;
    chr_cnt_d   = chr_cnt_q;
    shift_val_d = shift_val_q;
    shift_cnt_d = shift_cnt_q;
    ctrl_d      = ctrl_q;
    chr_lo_d    = chr_lo_q;
    chr_hi_d    = chr_hi_q;
    chr_all_d   = chr_all_q;
    prg_lo_d    = prg_lo_q;
    prg_hi_d    = prg_hi_q;
    prg_all_d   = prg_all_q;
    mirror_d    = mirror_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == sbsm_pkg::CFG_PRG_BANK_COUNT) begin
        prg_cnt_d = cfg_data_i;
        prg_hi_d  = last_bank_cfg[3:0];
      end else if (cfg_idx_i == sbsm_pkg::CFG_CHR_BANK_COUNT) begin
        chr_cnt_d = cfg_data_i;
      end
    end else if (acc_i && (op == sbsm_pkg::OP_CPU_WRITE) && in_rom) begin
      if (wdata_i[7]) begin
        shift_val_d = '0;
        shift_cnt_d = '0;
        ctrl_d      = ctrl_q | 5'h0C;
      end else if (shift_cnt_q == sbsm_pkg::SHIFT_LAST) begin
        shift_val_d = '0;
        shift_cnt_d = '0;
        unique case (sel)
          sbsm_pkg::REG_CONTROL: begin
            ctrl_d   = shifted;
            mirror_d = shifted[1:0];
          end
          sbsm_pkg::REG_CHR_LOW: begin
            if (ctrl_q[4]) begin
              chr_lo_d = shifted;
            end else begin
              chr_all_d = {shifted[4:1], 1'b0};
            end
          end
          sbsm_pkg::REG_CHR_HIGH: begin
            if (ctrl_q[4]) begin
              chr_hi_d = shifted;
            end
          end
          sbsm_pkg::REG_PRG: begin
            if (!ctrl_q[3]) begin
              prg_all_d = shifted[3:1];
            end else if (!ctrl_q[2]) begin
              prg_lo_d = '0;
              prg_hi_d = shifted[3:0];
            end else begin
              prg_lo_d = shifted[3:0];
              prg_hi_d = last_bank_cur[3:0];
            end
          end
          default: ;
        endcase
      end else begin
        shift_val_d = shifted;
        shift_cnt_d = shift_cnt_q + 3'd1;
      end
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.mirroring = mirror_d;
    ram_req_o.re    = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = ram_off[sbsm_pkg::RAM_AW-1:0];
    ram_req_o.wdata = wdata_i;
    if (is_cpu) begin
      if (in_ram) begin
        res_o.ram_access = 1'b1;
        res_o.ram_read   = op == sbsm_pkg::OP_CPU_READ;
        ram_req_o.re     = acc_i && (op == sbsm_pkg::OP_CPU_READ);
        ram_req_o.we     = acc_i && (op == sbsm_pkg::OP_CPU_WRITE);
      end else if (in_rom && (op == sbsm_pkg::OP_CPU_READ)) begin
        res_o.hit = 1'b1;
        if (ctrl_q[3]) begin
          res_o.mapped_address = {prg_bank, addr_i[13:0]};
        end else begin
          res_o.mapped_address = {prg_all_q, addr_i[14:0]};
        end
      end
    end else if (in_chr) begin
      if (chr_cnt_q == 5'd0) begin
        res_o.hit            = 1'b1;
        res_o.mapped_address = {5'b00000, addr_i[12:0]};
      end else if (op == sbsm_pkg::OP_PPU_READ) begin
        res_o.hit = 1'b1;
        if (ctrl_q[4]) begin
          res_o.mapped_address = {1'b0, chr_bank, addr_i[11:0]};
        end else begin
          res_o.mapped_address = {1'b0, chr_all_q[4:1], addr_i[12:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q   <= 5'd2;
      chr_cnt_q   <= '0;
      shift_val_q <= '0;
      shift_cnt_q <= '0;
      ctrl_q      <= sbsm_pkg::CONTROL_RESET;
      chr_lo_q    <= '0;
      chr_hi_q    <= '0;
      chr_all_q   <= '0;
      prg_lo_q    <= '0;
      prg_hi_q    <= 4'd1;
      prg_all_q   <= '0;
      mirror_q    <= '0;
    end else begin
      prg_cnt_q   <= prg_cnt_d;
      chr_cnt_q   <= chr_cnt_d;
      shift_val_q <= shift_val_d;
      shift_cnt_q <= shift_cnt_d;
      ctrl_q      <= ctrl_d;
      chr_lo_q    <= chr_lo_d;
      chr_hi_q    <= chr_hi_d;
      chr_all_q   <= chr_all_d;
      prg_lo_q    <= prg_lo_d;
      prg_hi_q    <= prg_hi_d;
      prg_all_q   <= prg_all_d;
      mirror_q    <= mirror_d;
    end
  end

endmodule

FILE: design/serial_bank_switch_mapper_top.sv
// Serial bank-switching cartridge mapper.
// in_i carries one CPU or PPU bus access per word (op, bus_address, write_data);
// out_o returns one result word per access, in order (hit, ram_access,
// mapped_address, read_data, mirroring). cfg_i writes the bank counts:
// index 0 program ROM banks, index 1 pattern ROM banks (0 = pattern RAM).
// Write configuration only while no access is in flight.
// A result is valid in the cycle after acceptance; one access is taken every
// cycle unless the receiver stalls. Mapper registers and translation settle in
// the accept cycle; the program RAM is a synchronous memory with one read or
// write per cycle; its registered read data lines up with the output register.
// Each access touches the RAM at most once, so no two accesses hit it in the same cycle.
// in_i.ready is high whenever the output register is empty or being drained;
// while the receiver stalls the result holds and at most one access waits.
// Reset clears the shifter and banks (high program bank to 1), sets control to
// 16 kB program mode with the last bank fixed high, 4 kB pattern mode, one-screen
// low mirroring, and bank counts 2 and 0. Program RAM is undefined until written.
module serial_bank_switch_mapper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbsm_in_if.sink     in_i,
  sbsm_out_if.source  out_o,
  sbsm_cfg_if.sink    cfg_i
);

  logic               in_acc;
  logic               cfg_we;
  logic               out_valid_q;
  sbsm_pkg::res_t     res;
  sbsm_pkg::res_t     res_q;
  sbsm_pkg::ram_req_t ram_req;
  logic [7:0]         ram_rdata;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  sbsm_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .op_i       (in_i.op),
    .addr_i     (in_i.bus_address),
    .wdata_i    (in_i.write_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .res_o      (res),
    .ram_req_o  (ram_req)
  );

  sbsm_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.hit            = res_q.hit;
  assign out_o.ram_access     = res_q.ram_access;
  assign out_o.mapped_address = res_q.mapped_address;
  assign out_o.read_data      = res_q.ram_read ? ram_rdata : 8'h00;
  assign out_o.mirroring      = res_q.mirroring;

`ifndef SYNTHESIS
  a_acc_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted word produced no result");

  a_hit_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.hit && res_q.ram_access))
    else $error("result both ROM hit and RAM access");

  a_rdata_ram_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.ram_read) |-> res_q.ram_access && !res_q.hit)
    else $error("RAM read data on non-RAM access");

  a_ram_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.re && ram_req.we))
    else $error("RAM read and write in one cycle");
`endif

endmodule
